/* hw/rtl/aefd_pkg.sv */
// Shared constants, codes and types of the alarm event frame decoder.
// No dependencies; used by the channel interfaces and the core.
`default_nettype none

package aefd_pkg;

    localparam int MAX_LEN    = 64;
    localparam int HEAD_DEPTH = 9;
    localparam int HEAD_IDX_W = $clog2(HEAD_DEPTH);
    localparam int CNT_W      = $clog2(MAX_LEN + 1);
    localparam int LEN_W      = CNT_W + 1;

    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int DEVICE_W   = 24;
    localparam int MODEL_W    = 16;
    localparam int DESYNC_W   = 32;

    localparam logic [BYTE_W-1:0] END_BYTE_RST       = 8'd126;
    localparam logic [BYTE_W-1:0] TEST_CODE_RST      = 8'd112;
    localparam logic [BYTE_W-1:0] BASE_CODE_RST      = 8'd121;
    localparam logic [BYTE_W-1:0] EMERGENCY_CODE_RST = 8'd80;
    localparam logic [BYTE_W-1:0] SILENCE_CODE_RST   = 8'd97;
    localparam logic [BYTE_W-1:0] MISSING_CODE_RST   = 8'd209;

    localparam int TEST_MIN_LEN      = 11;
    localparam int BASE_MIN_LEN      = 10;
    localparam int EMERGENCY_MIN_LEN = 9;
    localparam int SILENCE_MIN_LEN   = 5;
    localparam int MISSING_MIN_LEN   = 14;

    localparam logic [BYTE_W-1:0] TEST_PASS_VAL    = 8'h01;
    localparam logic [BYTE_W-1:0] BASE_ATTACH_MASK = 8'h04;
    localparam logic [BYTE_W-1:0] BASE_BATT_MASK   = 8'h42;

    typedef enum logic [1:0] {
        ST_EVENT       = 2'd0,
        ST_UNDECODABLE = 2'd1,
        ST_SYNC_LOST   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        KIND_TEST      = 3'd0,
        KIND_BASE      = 3'd1,
        KIND_EMERGENCY = 3'd2,
        KIND_SILENCE   = 3'd3,
        KIND_MISSING   = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_END_BYTE       = 3'd0,
        CFG_TEST_CODE      = 3'd1,
        CFG_BASE_CODE      = 3'd2,
        CFG_EMERGENCY_CODE = 3'd3,
        CFG_SILENCE_CODE   = 3'd4,
        CFG_MISSING_CODE   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_status               frame_status;
        t_kind                 event_kind;
        logic [DEVICE_W-1:0]   device_id;
        logic [MODEL_W-1:0]    model_id;
        logic [BYTE_W-1:0]     trigger_code;
        logic                  trigger_valid;
        logic                  test_passed;
        logic                  battery_good;
        logic                  battery_valid;
        logic                  base_attached;
        logic                  base_valid;
        logic [DESYNC_W-1:0]   desync_total;
    } t_evt;

endpackage

`default_nettype wire

/* hw/rtl/aefd_rx_if.sv */
// Byte input channel: valid/ready handshake carrying one received byte.
// Depends on aefd_pkg for widths.
`default_nettype none

interface aefd_rx_if;
    logic                        valid;
    logic                        ready;
    logic [aefd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* hw/rtl/aefd_evt_if.sv */
// Event record output channel: valid/ready handshake carrying one decoded record.
// Depends on aefd_pkg for widths.
`default_nettype none

interface aefd_evt_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    frame_status;
    logic [2:0]                    event_kind;
    logic [aefd_pkg::DEVICE_W-1:0] device_id;
    logic [aefd_pkg::MODEL_W-1:0]  model_id;
    logic [aefd_pkg::BYTE_W-1:0]   trigger_code;
    logic                          trigger_valid;
    logic                          test_passed;
    logic                          battery_good;
    logic                          battery_valid;
    logic                          base_attached;
    logic                          base_valid;
    logic [aefd_pkg::DESYNC_W-1:0] desync_total;

    modport source (
        output valid, output frame_status, output event_kind, output device_id,
        output model_id, output trigger_code, output trigger_valid, output test_passed,
        output battery_good, output battery_valid, output base_attached,
        output base_valid, output desync_total, input ready
    );
    modport sink (
        input valid, input frame_status, input event_kind, input device_id,
        input model_id, input trigger_code, input trigger_valid, input test_passed,
        input battery_good, input battery_valid, input base_attached,
        input base_valid, input desync_total, output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/alarm_event_frame_decoder_core.sv */
// Alarm event frame decoder core: frames bytes on a terminator and decodes event records.
// Depends on aefd_pkg, aefd_rx_if and aefd_evt_if.
// A record is registered and appears on o_evt in the cycle after the beat that ends or overflows a frame.
// Throughput: one byte per cycle; input stalls only while a record waits and o_evt is not ready.
// Reset (i_rst_n low, synchronous): counters and hunt flag clear, registers take reset codes.
// Reset: the output register empties; the frame head bytes keep their contents.
`default_nettype none

module alarm_event_frame_decoder_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [aefd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [aefd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    aefd_rx_if.sink                              i_rx,
    aefd_evt_if.source                           o_evt
);

    logic [aefd_pkg::BYTE_W-1:0]   r_end_byte;
    logic [aefd_pkg::BYTE_W-1:0]   r_test_code;
    logic [aefd_pkg::BYTE_W-1:0]   r_base_code;
    logic [aefd_pkg::BYTE_W-1:0]   r_emergency_code;
    logic [aefd_pkg::BYTE_W-1:0]   r_silence_code;
    logic [aefd_pkg::BYTE_W-1:0]   r_missing_code;

    logic                          r_hunting;
    logic                          n_hunting;
    logic [aefd_pkg::CNT_W-1:0]    r_count;
    logic [aefd_pkg::CNT_W-1:0]    n_count;
    logic [aefd_pkg::DESYNC_W-1:0] r_desync;
    logic [aefd_pkg::DESYNC_W-1:0] n_desync;
    logic [aefd_pkg::BYTE_W-1:0]   r_head [aefd_pkg::HEAD_DEPTH];

    logic                          r_out_valid;
    aefd_pkg::t_evt                r_evt;
    aefd_pkg::t_evt                n_evt;

    logic                          rx_accept;
    logic                          is_end;
    logic                          overflow;
    logic                          emit;
    logic                          head_we;
    logic [aefd_pkg::LEN_W-1:0]    len;
    aefd_pkg::t_evt                dec;
    logic                          dec_ok;

    assign i_rx.ready = !r_out_valid || o_evt.ready;
    assign rx_accept  = i_rx.valid && i_rx.ready;
    assign is_end     = (i_rx.rx_byte == r_end_byte);
    assign len        = {1'b0, r_count} + aefd_pkg::LEN_W'(1);
    assign overflow   = !is_end && (len > aefd_pkg::LEN_W'(aefd_pkg::MAX_LEN));
    assign emit       = rx_accept && !r_hunting && (is_end || overflow);
    assign head_we    = rx_accept && !r_hunting &&
                        (r_count < aefd_pkg::CNT_W'(aefd_pkg::HEAD_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_byte       <= aefd_pkg::END_BYTE_RST;
            r_test_code      <= aefd_pkg::TEST_CODE_RST;
            r_base_code      <= aefd_pkg::BASE_CODE_RST;
            r_emergency_code <= aefd_pkg::EMERGENCY_CODE_RST;
            r_silence_code   <= aefd_pkg::SILENCE_CODE_RST;
            r_missing_code   <= aefd_pkg::MISSING_CODE_RST;
        end else if (i_cfg_we) begin
            unique case (aefd_pkg::t_cfg_idx'(i_cfg_idx))
                aefd_pkg::CFG_END_BYTE:       r_end_byte       <= i_cfg_data;
                aefd_pkg::CFG_TEST_CODE:      r_test_code      <= i_cfg_data;
                aefd_pkg::CFG_BASE_CODE:      r_base_code      <= i_cfg_data;
                aefd_pkg::CFG_EMERGENCY_CODE: r_emergency_code <= i_cfg_data;
                aefd_pkg::CFG_SILENCE_CODE:   r_silence_code   <= i_cfg_data;
                aefd_pkg::CFG_MISSING_CODE:   r_missing_code   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_hunting = r_hunting;
        n_count   = r_count;
        n_desync  = r_desync;
        if (rx_accept) begin
            if (r_hunting) begin
                if (is_end) begin
                    n_hunting = 1'b0;
                end
            end else if (is_end) begin
                n_count = '0;
            end else if (overflow) begin
                n_count   = '0;
                n_hunting = 1'b1;
                n_desync  = r_desync + aefd_pkg::DESYNC_W'(1);
            end else begin
                n_count = len[aefd_pkg::CNT_W-1:0];
            end
        end
    end

    always_comb begin
        dec        = '0;
        dec_ok     = 1'b0;
        priority if (r_head[0] == r_test_code) begin
            dec_ok             = (len >= aefd_pkg::LEN_W'(aefd_pkg::TEST_MIN_LEN));
            dec.event_kind     = aefd_pkg::KIND_TEST;
            dec.device_id      = {r_head[1], r_head[2], r_head[3]};
            dec.trigger_code   = r_head[4];
            dec.trigger_valid  = 1'b1;
            dec.test_passed    = (r_head[5] == aefd_pkg::TEST_PASS_VAL);
            dec.model_id       = {r_head[6], r_head[7]};
            dec.battery_good   = (r_head[5] == aefd_pkg::TEST_PASS_VAL);
            dec.battery_valid  = 1'b1;
            dec.base_attached  = 1'b1;
            dec.base_valid     = 1'b1;
        end else if (r_head[0] == r_base_code) begin
            dec_ok             = (len >= aefd_pkg::LEN_W'(aefd_pkg::BASE_MIN_LEN));
            dec.event_kind     = aefd_pkg::KIND_BASE;
            dec.device_id      = {r_head[1], r_head[2], r_head[3]};
            dec.model_id       = {r_head[4], r_head[5]};
            dec.base_attached  = |(r_head[6] & aefd_pkg::BASE_ATTACH_MASK);
            dec.base_valid     = 1'b1;
            dec.battery_good   = ~|(r_head[6] & aefd_pkg::BASE_BATT_MASK);
            dec.battery_valid  = 1'b1;
        end else if (r_head[0] == r_emergency_code) begin
            dec_ok             = (len >= aefd_pkg::LEN_W'(aefd_pkg::EMERGENCY_MIN_LEN));
            dec.event_kind     = aefd_pkg::KIND_EMERGENCY;
            dec.device_id      = {r_head[1], r_head[2], r_head[3]};
            dec.trigger_code   = r_head[4];
            dec.trigger_valid  = 1'b1;
            dec.base_attached  = 1'b1;
            dec.base_valid     = 1'b1;
        end else if (r_head[0] == r_silence_code) begin
            dec_ok             = (len >= aefd_pkg::LEN_W'(aefd_pkg::SILENCE_MIN_LEN));
            dec.event_kind     = aefd_pkg::KIND_SILENCE;
            dec.device_id      = {r_head[1], r_head[2], r_head[3]};
            dec.base_attached  = 1'b1;
            dec.base_valid     = 1'b1;
        end else if (r_head[0] == r_missing_code) begin
            dec_ok             = (len >= aefd_pkg::LEN_W'(aefd_pkg::MISSING_MIN_LEN));
            dec.event_kind     = aefd_pkg::KIND_MISSING;
            dec.device_id      = {r_head[6], r_head[7], r_head[8]};
        end else begin
            dec_ok             = 1'b0;
        end
    end

    always_comb begin
        n_evt = '0;
        if (overflow) begin
            n_evt.frame_status = aefd_pkg::ST_SYNC_LOST;
        end else if (dec_ok && (len != aefd_pkg::LEN_W'(1))) begin
            n_evt              = dec;
            n_evt.frame_status = aefd_pkg::ST_EVENT;
        end else begin
            n_evt.frame_status = aefd_pkg::ST_UNDECODABLE;
        end
        n_evt.desync_total = n_desync;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunting   <= 1'b0;
            r_count     <= '0;
            r_desync    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_hunting <= n_hunting;
            r_count   <= n_count;
            r_desync  <= n_desync;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_evt.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_head[r_count[aefd_pkg::HEAD_IDX_W-1:0]] <= i_rx.rx_byte;
        end
        if (emit) begin
            r_evt <= n_evt;
        end
    end

    assign o_evt.valid         = r_out_valid;
    assign o_evt.frame_status  = r_evt.frame_status;
    assign o_evt.event_kind    = r_evt.event_kind;
    assign o_evt.device_id     = r_evt.device_id;
    assign o_evt.model_id      = r_evt.model_id;
    assign o_evt.trigger_code  = r_evt.trigger_code;
    assign o_evt.trigger_valid = r_evt.trigger_valid;
    assign o_evt.test_passed   = r_evt.test_passed;
    assign o_evt.battery_good  = r_evt.battery_good;
    assign o_evt.battery_valid = r_evt.battery_valid;
    assign o_evt.base_attached = r_evt.base_attached;
    assign o_evt.base_valid    = r_evt.base_valid;
    assign o_evt.desync_total  = r_evt.desync_total;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= aefd_pkg::CNT_W'(aefd_pkg::MAX_LEN))
        else $error("frame byte count beyond maximum length");

    a_hunt_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hunting |-> (r_count == '0))
        else $error("byte count moved while hunting for terminator");

    a_sync_lost_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_accept && !r_hunting && overflow) |=>
            (o_evt.valid && r_hunting &&
             (o_evt.frame_status == aefd_pkg::ST_SYNC_LOST) &&
             (o_evt.desync_total == $past(r_desync) + aefd_pkg::DESYNC_W'(1))))
        else $error("overflow did not yield a sync lost record with bumped count");

    a_no_emit_hunting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_accept && r_hunting && !o_evt.ready) |=> $stable(r_evt))
        else $error("record changed on a beat dropped while hunting");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt.valid && (o_evt.frame_status != aefd_pkg::ST_EVENT)) |->
            ((o_evt.device_id == '0) && (o_evt.model_id == '0) &&
             (o_evt.event_kind == '0) && !o_evt.trigger_valid && !o_evt.base_valid))
        else $error("failed record carries nonzero fields");
`endif

endmodule

`default_nettype wire

/* dv/tb_alarm_event_frame_decoder_core.sv */
`timescale 1ns / 1ps
// Testbench for alarm_event_frame_decoder_core: sends framed radio bytes with random gaps
// and output stalls, predicts each event record and checks it field by field.
// Depends on aefd_pkg, aefd_rx_if, aefd_evt_if and the core.

module tb_alarm_event_frame_decoder_core;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int BYTE_TARGET    = 1650;
    localparam int NUM_PHASES     = 6;
    localparam int MAX_PRINTS     = 40;

    class evt_scoreboard;
        logic [aefd_pkg::BYTE_W-1:0]   regs [0:5];
        bit                            hunting;
        logic [aefd_pkg::BYTE_W-1:0]   head [0:aefd_pkg::HEAD_DEPTH-1];
        int unsigned                   byte_count;
        logic [aefd_pkg::DESYNC_W-1:0] desync_count;
        aefd_pkg::t_evt                pending [$];
        int unsigned                   errors;

        function new();
            regs[aefd_pkg::CFG_END_BYTE]       = aefd_pkg::END_BYTE_RST;
            regs[aefd_pkg::CFG_TEST_CODE]      = aefd_pkg::TEST_CODE_RST;
            regs[aefd_pkg::CFG_BASE_CODE]      = aefd_pkg::BASE_CODE_RST;
            regs[aefd_pkg::CFG_EMERGENCY_CODE] = aefd_pkg::EMERGENCY_CODE_RST;
            regs[aefd_pkg::CFG_SILENCE_CODE]   = aefd_pkg::SILENCE_CODE_RST;
            regs[aefd_pkg::CFG_MISSING_CODE]   = aefd_pkg::MISSING_CODE_RST;
            hunting      = 1'b0;
            byte_count   = 0;
            desync_count = '0;
            errors       = 0;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS) begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
        endtask

        function aefd_pkg::t_evt predict_record(int unsigned len);
            aefd_pkg::t_evt              e;
            logic [aefd_pkg::BYTE_W-1:0] lead;
            e    = '0;
            lead = head[0];
            if (lead == regs[aefd_pkg::CFG_TEST_CODE]) begin
                if (len >= aefd_pkg::TEST_MIN_LEN) begin
                    e.event_kind    = aefd_pkg::KIND_TEST;
                    e.device_id     = {head[1], head[2], head[3]};
                    e.trigger_code  = head[4];
                    e.trigger_valid = 1'b1;
                    e.test_passed   = (head[5] == aefd_pkg::TEST_PASS_VAL);
                    e.model_id      = {head[6], head[7]};
                    e.battery_good  = e.test_passed;
                    e.battery_valid = 1'b1;
                    e.base_attached = 1'b1;
                    e.base_valid    = 1'b1;
                end else begin
                    e.frame_status = aefd_pkg::ST_UNDECODABLE;
                end
            end else if (lead == regs[aefd_pkg::CFG_BASE_CODE]) begin
                if (len >= aefd_pkg::BASE_MIN_LEN) begin
                    e.event_kind    = aefd_pkg::KIND_BASE;
                    e.device_id     = {head[1], head[2], head[3]};
                    e.model_id      = {head[4], head[5]};
                    e.base_attached = (head[6] & aefd_pkg::BASE_ATTACH_MASK) != 0;
                    e.base_valid    = 1'b1;
                    e.battery_good  = (head[6] & aefd_pkg::BASE_BATT_MASK) == 0;
                    e.battery_valid = 1'b1;
                end else begin
                    e.frame_status = aefd_pkg::ST_UNDECODABLE;
                end
            end else if (lead == regs[aefd_pkg::CFG_EMERGENCY_CODE]) begin
                if (len >= aefd_pkg::EMERGENCY_MIN_LEN) begin
                    e.event_kind    = aefd_pkg::KIND_EMERGENCY;
                    e.device_id     = {head[1], head[2], head[3]};
                    e.trigger_code  = head[4];
                    e.trigger_valid = 1'b1;
                    e.base_attached = 1'b1;
                    e.base_valid    = 1'b1;
                end else begin
                    e.frame_status = aefd_pkg::ST_UNDECODABLE;
                end
            end else if (lead == regs[aefd_pkg::CFG_SILENCE_CODE]) begin
                if (len >= aefd_pkg::SILENCE_MIN_LEN) begin
                    e.event_kind    = aefd_pkg::KIND_SILENCE;
                    e.device_id     = {head[1], head[2], head[3]};
                    e.base_attached = 1'b1;
                    e.base_valid    = 1'b1;
                end else begin
                    e.frame_status = aefd_pkg::ST_UNDECODABLE;
                end
            end else if (lead == regs[aefd_pkg::CFG_MISSING_CODE]) begin
                if (len >= aefd_pkg::MISSING_MIN_LEN) begin
                    e.event_kind = aefd_pkg::KIND_MISSING;
                    e.device_id  = {head[6], head[7], head[8]};
                end else begin
                    e.frame_status = aefd_pkg::ST_UNDECODABLE;
                end
            end else begin
                e.frame_status = aefd_pkg::ST_UNDECODABLE;
            end
            e.desync_total = desync_count;
            return e;
        endfunction

        function void note_byte(logic [aefd_pkg::BYTE_W-1:0] b);
            aefd_pkg::t_evt e;
            if (hunting) begin
                if (b == regs[aefd_pkg::CFG_END_BYTE]) begin
                    hunting = 1'b0;
                end
                return;
            end
            if (byte_count < aefd_pkg::HEAD_DEPTH) begin
                head[byte_count] = b;
            end
            byte_count++;
            if (b == regs[aefd_pkg::CFG_END_BYTE]) begin
                e          = predict_record(byte_count);
                byte_count = 0;
                pending    = {pending, e};
            end else if (byte_count > aefd_pkg::MAX_LEN) begin
                byte_count     = 0;
                hunting        = 1'b1;
                desync_count   = desync_count + 1;
                e              = '0;
                e.frame_status = aefd_pkg::ST_SYNC_LOST;
                e.desync_total = desync_count;
                pending        = {pending, e};
            end
        endfunction

        task cmp(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) begin
                report($sformatf("%s got %0h want %0h", name, got, want));
            end
        endtask

        task check_evt(aefd_pkg::t_evt got);
            aefd_pkg::t_evt want;
            if (pending.size() == 0) begin
                report($sformatf("record with nothing pending: %h", got));
                return;
            end
            want = pending.pop_front();
            cmp("frame_status", got.frame_status, want.frame_status);
            cmp("event_kind", got.event_kind, want.event_kind);
            cmp("device_id", got.device_id, want.device_id);
            cmp("model_id", got.model_id, want.model_id);
            cmp("trigger_code", got.trigger_code, want.trigger_code);
            cmp("trigger_valid", got.trigger_valid, want.trigger_valid);
            cmp("test_passed", got.test_passed, want.test_passed);
            cmp("battery_good", got.battery_good, want.battery_good);
            cmp("battery_valid", got.battery_valid, want.battery_valid);
            cmp("base_attached", got.base_attached, want.base_attached);
            cmp("base_valid", got.base_valid, want.base_valid);
            cmp("desync_total", got.desync_total, want.desync_total);
        endtask
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [aefd_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [aefd_pkg::CFG_DATA_W-1:0] cfg_data;
    bit                              idle_en;
    int unsigned                     sent;
    int unsigned                     quiet_cycles;
    evt_scoreboard                   sb;

    aefd_rx_if  rx ();
    aefd_evt_if evt ();

    alarm_event_frame_decoder_core i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_rx       (rx),
        .o_evt      (evt)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        evt.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (idle_en && $urandom_range(0, 5) == 0) begin
                evt.ready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge clk);
            end else begin
                evt.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : evt_monitor
        aefd_pkg::t_evt got;
        if (rst_n && evt.valid && evt.ready) begin
            got.frame_status  = aefd_pkg::t_status'(evt.frame_status);
            got.event_kind    = aefd_pkg::t_kind'(evt.event_kind);
            got.device_id     = evt.device_id;
            got.model_id      = evt.model_id;
            got.trigger_code  = evt.trigger_code;
            got.trigger_valid = evt.trigger_valid;
            got.test_passed   = evt.test_passed;
            got.battery_good  = evt.battery_good;
            got.battery_valid = evt.battery_valid;
            got.base_attached = evt.base_attached;
            got.base_valid    = evt.base_valid;
            got.desync_total  = evt.desync_total;
            sb.check_evt(got);
        end
    end

    always @(posedge clk) begin
        if ((rx.valid && rx.ready) || (evt.valid && evt.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_byte(input logic [aefd_pkg::BYTE_W-1:0] b);
        int unsigned gap;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            @(negedge clk);
            rx.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        @(posedge clk);
        while (!rx.ready) @(posedge clk);
        sb.note_byte(b);
        sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        rx.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input aefd_pkg::t_cfg_idx idx,
                             input logic [aefd_pkg::CFG_DATA_W-1:0] v);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v;
        @(posedge clk);
        sb.regs[idx] = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic [7:0] term, input logic [7:0] tst,
                             input logic [7:0] bas, input logic [7:0] emg,
                             input logic [7:0] sil, input logic [7:0] mis);
        write_reg(aefd_pkg::CFG_END_BYTE, term);
        write_reg(aefd_pkg::CFG_TEST_CODE, tst);
        write_reg(aefd_pkg::CFG_BASE_CODE, bas);
        write_reg(aefd_pkg::CFG_EMERGENCY_CODE, emg);
        write_reg(aefd_pkg::CFG_SILENCE_CODE, sil);
        write_reg(aefd_pkg::CFG_MISSING_CODE, mis);
    endtask

    // payload byte that never ends the frame early; leans toward field extremes
    function automatic logic [aefd_pkg::BYTE_W-1:0] body_byte(input int unsigned pos);
        logic [aefd_pkg::BYTE_W-1:0] b;
        do begin
            case ($urandom_range(0, 7))
                0: b = 8'h00;
                1: b = 8'hFF;
                2: b = (pos == 5) ? aefd_pkg::TEST_PASS_VAL : aefd_pkg::BASE_ATTACH_MASK;
                default: b = 8'($urandom_range(0, 255));
            endcase
        end while (b == sb.regs[aefd_pkg::CFG_END_BYTE]);
        return b;
    endfunction

    task automatic send_frame(input logic [aefd_pkg::BYTE_W-1:0] lead,
                              input int unsigned len);
        if (len > 1) begin
            send_byte(lead);
            for (int unsigned k = 1; k + 1 < len; k++) begin
                send_byte(body_byte(k));
            end
        end
        send_byte(sb.regs[aefd_pkg::CFG_END_BYTE]);
    endtask

    task automatic lose_sync();
        repeat (aefd_pkg::MAX_LEN + 1) send_byte(body_byte(0));
        repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(0, 255)));
        send_byte(sb.regs[aefd_pkg::CFG_END_BYTE]);
    endtask

    task automatic random_frame();
        aefd_pkg::t_kind             kind;
        logic [aefd_pkg::BYTE_W-1:0] lead;
        int unsigned                 min_len;
        int unsigned                 len;
        int unsigned                 sel;
        kind = aefd_pkg::t_kind'($urandom_range(0, 4));
        case (kind)
            aefd_pkg::KIND_TEST: begin
                lead    = sb.regs[aefd_pkg::CFG_TEST_CODE];
                min_len = aefd_pkg::TEST_MIN_LEN;
            end
            aefd_pkg::KIND_BASE: begin
                lead    = sb.regs[aefd_pkg::CFG_BASE_CODE];
                min_len = aefd_pkg::BASE_MIN_LEN;
            end
            aefd_pkg::KIND_EMERGENCY: begin
                lead    = sb.regs[aefd_pkg::CFG_EMERGENCY_CODE];
                min_len = aefd_pkg::EMERGENCY_MIN_LEN;
            end
            aefd_pkg::KIND_SILENCE: begin
                lead    = sb.regs[aefd_pkg::CFG_SILENCE_CODE];
                min_len = aefd_pkg::SILENCE_MIN_LEN;
            end
            default: begin
                lead    = sb.regs[aefd_pkg::CFG_MISSING_CODE];
                min_len = aefd_pkg::MISSING_MIN_LEN;
            end
        endcase
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            len = min_len + $urandom_range(0, 4);
        end else if (sel < 76) begin
            len = $urandom_range(min_len, aefd_pkg::MAX_LEN);
        end else if (sel < 80) begin
            len = aefd_pkg::MAX_LEN + $urandom_range(0, 1);
        end else if (sel < 88) begin
            len = $urandom_range(1, min_len - 1);
        end else if (sel < 94) begin
            lead = 8'($urandom_range(0, 255));
            len  = $urandom_range(2, 16);
        end else if (sel < 97) begin
            lose_sync();
            return;
        end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        send_frame(lead, len);
    endtask

    task automatic directed_frames();
        send_byte(sb.regs[aefd_pkg::CFG_END_BYTE]);
        send_byte(sb.regs[aefd_pkg::CFG_SILENCE_CODE]);
        repeat (3) send_byte(8'hFF);
        send_byte(sb.regs[aefd_pkg::CFG_END_BYTE]);
        send_byte(sb.regs[aefd_pkg::CFG_SILENCE_CODE]);
        repeat (2) send_byte(8'h00);
        send_byte(sb.regs[aefd_pkg::CFG_END_BYTE]);
        send_byte(sb.regs[aefd_pkg::CFG_EMERGENCY_CODE]);
        repeat (3) send_byte(8'h00);
        send_byte(8'hFF);
        repeat (3) send_byte(8'h00);
        send_byte(sb.regs[aefd_pkg::CFG_END_BYTE]);
        send_byte(8'h00);
        send_byte(sb.regs[aefd_pkg::CFG_END_BYTE]);
        send_byte(8'hFF);
        send_byte(sb.regs[aefd_pkg::CFG_END_BYTE]);
    endtask

    initial begin
        sb           = new();
        sent         = 0;
        quiet_cycles = 0;
        idle_en      = 1'b1;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        rx.valid     = 1'b0;
        rx.rx_byte   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            idle_en = (p != NUM_PHASES - 1);
            case (p)
                0: directed_frames();
                2: write_all(8'h00, 8'hFF, 8'hFF, 8'h01, 8'h80, 8'hFE);
                3: write_all(8'hFF, 8'h00, 8'h01, 8'h01, 8'h00, 8'hFE);
                NUM_PHASES - 1: write_all(aefd_pkg::END_BYTE_RST, aefd_pkg::TEST_CODE_RST,
                                          aefd_pkg::BASE_CODE_RST,
                                          aefd_pkg::EMERGENCY_CODE_RST,
                                          aefd_pkg::SILENCE_CODE_RST,
                                          aefd_pkg::MISSING_CODE_RST);
                default: write_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
            while (sent < (p + 1) * BYTE_TARGET / NUM_PHASES) random_frame();
            settle();
        end

        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
